// File: rtl/cbc_pkg.sv
package cbc_pkg;

  // Physical address widths
  localparam int ROM_ADDR_BITS = 21;
  localparam int RAM_BANKS     = 4;
  localparam int MAP_W         = 21;

  // Mapper codes (cartridge header)
  localparam logic [1:0] MAPPER_NONE = 2'd0;
  localparam logic [1:0] MAPPER_MBC1 = 2'd1;
  localparam logic [1:0] MAPPER_MBC2 = 2'd2;

  // Result region codes
  localparam logic [1:0] REGION_OTHER = 2'd0;
  localparam logic [1:0] REGION_ROM   = 2'd1;
  localparam logic [1:0] REGION_RAM   = 2'd2;
  localparam logic [1:0] REGION_CTRL  = 2'd3;

  // Control write windows, address bits 14:13 below 0x8000
  localparam logic [1:0] CW_RAM_EN   = 2'd0;
  localparam logic [1:0] CW_ROM_LO   = 2'd1;
  localparam logic [1:0] CW_ROM_HI   = 2'd2;
  localparam logic [1:0] CW_MODE     = 2'd3;

  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [3:0] RAM_DIS_KEY = 4'h0;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        is_write;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]       region;
    logic [MAP_W-1:0] mapped_address;
    logic             ram_write_strobe;
    logic             ram_is_enabled;
  } rsp_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_enable;
    logic       rom_mode;
  } bank_state_t;

  // RAM bank number wrapped to the number of fitted banks
  function automatic logic [1:0] ram_bank_wrap(input logic [1:0] bank);
    logic [1:0] res;
    case (bank)
      2'd0:    res = 2'(0 % RAM_BANKS);
      2'd1:    res = 2'(1 % RAM_BANKS);
      2'd2:    res = 2'(2 % RAM_BANKS);
      default: res = 2'(3 % RAM_BANKS);
    endcase
    return res;
  endfunction

endpackage

// File: rtl/cbc_req_if.sv
interface cbc_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic        is_write;
  logic [7:0]  write_data;

  modport source(output valid, bus_address, is_write, write_data, input ready);
  modport sink(input valid, bus_address, is_write, write_data, output ready);
endinterface

// File: rtl/cbc_rsp_if.sv
interface cbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  region;
  logic [20:0] mapped_address;
  logic        ram_write_strobe;
  logic        ram_is_enabled;

  modport source(output valid, region, mapped_address, ram_write_strobe, ram_is_enabled,
                 input ready);
  modport sink(input valid, region, mapped_address, ram_write_strobe, ram_is_enabled,
               output ready);
endinterface

// File: rtl/cbc_cfg_if.sv
interface cbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: rtl/cbc_ctrl_regs.sv
module cbc_ctrl_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  input  logic                upd,
  input  cbc_pkg::req_t       req,
  output cbc_pkg::bank_state_t cur,
  output cbc_pkg::bank_state_t nxt
);

  logic [1:0]           mapper_type;
  cbc_pkg::bank_state_t state;
  cbc_pkg::bank_state_t state_next;

  function automatic logic [6:0] fix_zero_bank(input logic [6:0] b);
    return (b == 7'd0) ? 7'd1 : b;
  endfunction

  always_comb begin
    logic mbc1;
    logic mbc2;
    mbc1 = (mapper_type == cbc_pkg::MAPPER_MBC1);
    mbc2 = (mapper_type == cbc_pkg::MAPPER_MBC2);
    state_next = state;
    if (req.is_write && !req.bus_address[15]) begin
      unique case (req.bus_address[14:13])
        cbc_pkg::CW_RAM_EN: begin
          // MBC2 ignores this window when address bit 8 is set
          if ((mbc1 || mbc2) && !(mbc2 && req.bus_address[8])) begin
            if (req.write_data[3:0] == cbc_pkg::RAM_EN_KEY)
              state_next.ram_enable = 1'b1;
            else if (req.write_data[3:0] == cbc_pkg::RAM_DIS_KEY)
              state_next.ram_enable = 1'b0;
          end
        end
        cbc_pkg::CW_ROM_LO: begin
          if (mbc2)
            state_next.rom_bank = fix_zero_bank({3'd0, req.write_data[3:0]});
          else if (mbc1)
            state_next.rom_bank = fix_zero_bank({state.rom_bank[6:5], req.write_data[4:0]});
        end
        cbc_pkg::CW_ROM_HI: begin
          if (mbc1) begin
            if (state.rom_mode)
              state_next.rom_bank = fix_zero_bank({req.write_data[1:0], state.rom_bank[4:0]});
            else
              state_next.ram_bank = req.write_data[1:0];
          end
        end
        cbc_pkg::CW_MODE: begin
          if (mbc1) begin
            state_next.rom_mode = !req.write_data[0];
            if (!req.write_data[0])
              state_next.ram_bank = 2'd0;
          end
        end
        default: state_next = state;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_type      <= cbc_pkg::MAPPER_NONE;
      state.rom_bank   <= 7'd1;
      state.ram_bank   <= 2'd0;
      state.ram_enable <= 1'b0;
      state.rom_mode   <= 1'b0;
    end else begin
      if (cfg_we)
        mapper_type <= cfg_data;
      if (upd)
        state <= state_next;
    end
  end

  assign cur = state;
  assign nxt = state_next;

endmodule

// File: rtl/cbc_addr_map.sv
module cbc_addr_map (
  input  cbc_pkg::req_t        req,
  input  cbc_pkg::bank_state_t cur,
  input  logic                 ram_enable_next,
  output cbc_pkg::rsp_t        rsp
);

  logic [20:0] rom_full;
  logic [14:0] ram_full;

  // Bank number lands directly above the in-bank offset
  assign rom_full = {cur.rom_bank, req.bus_address[13:0]};
  assign ram_full = {cbc_pkg::ram_bank_wrap(cur.ram_bank), req.bus_address[12:0]};

  always_comb begin
    rsp.region           = cbc_pkg::REGION_OTHER;
    rsp.mapped_address   = cbc_pkg::MAP_W'(req.bus_address);
    rsp.ram_write_strobe = 1'b0;
    rsp.ram_is_enabled   = ram_enable_next;
    if (req.is_write && !req.bus_address[15]) begin
      rsp.region = cbc_pkg::REGION_CTRL;
    end else if (!req.is_write && req.bus_address[15:14] == 2'b01) begin
      rsp.region         = cbc_pkg::REGION_ROM;
      rsp.mapped_address = cbc_pkg::MAP_W'(rom_full[cbc_pkg::ROM_ADDR_BITS-1:0]);
    end else if (req.bus_address[15:13] == 3'b101) begin
      rsp.region           = cbc_pkg::REGION_RAM;
      rsp.mapped_address   = cbc_pkg::MAP_W'(ram_full);
      rsp.ram_write_strobe = req.is_write && cur.ram_enable;
    end
  end

endmodule

// File: rtl/cartridge_bank_controller_core.sv
// Channel | Dir | Payload                                         | Handshake
// req     | in  | bus_address, is_write, write_data               | valid/ready
// rsp     | out | region, mapped_address, ram_write_strobe,       | valid/ready
//         |     | ram_is_enabled                                  |
// cfg     | in  | data = mapper_type                              | valid/ready
//
// Request register, then result register: one request per cycle sustained while
// rsp does not stall; a taken request passes both registers before it is offered.
// Bank state updates as a request moves on, so it sees all earlier writes.
// rst (synchronous) empties both stages: rom bank 1, ram bank 0, RAM off,
// RAM banking mode, no mapper.
// A stalled rsp holds its result; req stalls only once both stages are full.
module cartridge_bank_controller_core (
  input logic        clk,
  input logic        rst,
  cbc_req_if.sink    req,
  cbc_rsp_if.source  rsp,
  cbc_cfg_if.sink    cfg
);

  // request stage
  logic                 req_vld;
  cbc_pkg::req_t        req_q;
  // result stage
  logic                 rsp_vld;
  cbc_pkg::rsp_t        rsp_q;

  cbc_pkg::bank_state_t bank_cur;
  cbc_pkg::bank_state_t bank_nxt;
  cbc_pkg::rsp_t        rsp_d;
  logic                 advance;

  // Request stage moves on when the result register is free or draining
  assign advance   = req_vld && (!rsp_vld || rsp.ready);
  assign req.ready = !req_vld || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
      rsp_vld <= 1'b0;
    end else begin
      if (req.ready)
        req_vld <= req.valid;
      if (advance)
        rsp_vld <= 1'b1;
      else if (rsp.ready)
        rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.bus_address <= req.bus_address;
      req_q.is_write    <= req.is_write;
      req_q.write_data  <= req.write_data;
    end
    if (advance)
      rsp_q <= rsp_d;
  end

  cbc_ctrl_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.data),
    .upd      (advance),
    .req      (req_q),
    .cur      (bank_cur),
    .nxt      (bank_nxt)
  );

  cbc_addr_map u_map (
    .req             (req_q),
    .cur             (bank_cur),
    .ram_enable_next (bank_nxt.ram_enable),
    .rsp             (rsp_d)
  );

  assign rsp.valid            = rsp_vld;
  assign rsp.region           = rsp_q.region;
  assign rsp.mapped_address   = rsp_q.mapped_address;
  assign rsp.ram_write_strobe = rsp_q.ram_write_strobe;
  assign rsp.ram_is_enabled   = rsp_q.ram_is_enabled;

  // RAM write strobe only for RAM window while enabled
  a_strobe_ram: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && rsp_q.ram_write_strobe
      |-> rsp_q.region == cbc_pkg::REGION_RAM && rsp_q.ram_is_enabled)
    else $error("strobe outside enabled RAM window");

  // A held request is never dropped
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_vld && !advance |=> req_vld && $stable(req_q))
    else $error("request stage lost a request");

  // ROM bank register never reads as zero
  a_rom_bank_nz: assert property (@(posedge clk) disable iff (rst)
    bank_cur.rom_bank != 7'd0)
    else $error("rom bank is zero");

endmodule

// File: sim/tb_cartridge_bank_controller_core.sv
module tb_cartridge_bank_controller_core;

  // Mapper code that the header may carry but that selects no mapper
  localparam logic [1:0] MAPPER_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 220;
  localparam int PLAN_LEN     = 30;

  typedef struct packed {
    logic          is_cfg;
    logic [1:0]    mapper;
    cbc_pkg::req_t acc;
    logic          typed;
    cbc_pkg::rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbc_req_if req_ch ();
  cbc_rsp_if rsp_ch ();
  cbc_cfg_if cfg_ch ();

  cartridge_bank_controller_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the bank registers
  logic [1:0]           mapper_sel;
  cbc_pkg::bank_state_t banks;

  cbc_pkg::rsp_t decoded_q [$];
  int   errors = 0;
  bit   back_to_back = 1'b0;
  int   hold_len = 0;
  int   quiet_cycles = 0;

  function automatic logic [6:0] nonzero_bank(input logic [6:0] b);
    return (b == 7'd0) ? 7'd1 : b;
  endfunction

  // Applies one access to the bank registers, returns the decoded result
  function automatic cbc_pkg::rsp_t decode_access(input cbc_pkg::req_t a);
    cbc_pkg::rsp_t r;
    logic       mbc1;
    logic       mbc2;
    logic [3:0] nib;
    int         wrap;
    logic [cbc_pkg::MAP_W-1:0] rom_mask;
    mbc1 = (mapper_sel == cbc_pkg::MAPPER_MBC1);
    mbc2 = (mapper_sel == cbc_pkg::MAPPER_MBC2);
    nib = a.write_data[3:0];
    rom_mask = cbc_pkg::MAP_W'((64'd1 << cbc_pkg::ROM_ADDR_BITS) - 64'd1);
    r.region = cbc_pkg::REGION_OTHER;
    r.mapped_address = cbc_pkg::MAP_W'(a.bus_address);
    r.ram_write_strobe = 1'b0;
    if (a.is_write && !a.bus_address[15]) begin
      r.region = cbc_pkg::REGION_CTRL;
      case (a.bus_address[14:13])
        cbc_pkg::CW_RAM_EN: begin
          if ((mbc1 || mbc2) && !(mbc2 && a.bus_address[8])) begin
            if (nib == cbc_pkg::RAM_EN_KEY) banks.ram_enable = 1'b1;
            else if (nib == cbc_pkg::RAM_DIS_KEY) banks.ram_enable = 1'b0;
          end
        end
        cbc_pkg::CW_ROM_LO: begin
          if (mbc2) banks.rom_bank = nonzero_bank({3'b000, a.write_data[3:0]});
          else if (mbc1)
            banks.rom_bank = nonzero_bank({banks.rom_bank[6:5], a.write_data[4:0]});
        end
        cbc_pkg::CW_ROM_HI: begin
          if (mbc1) begin
            if (banks.rom_mode)
              banks.rom_bank = nonzero_bank({a.write_data[1:0], banks.rom_bank[4:0]});
            else
              banks.ram_bank = a.write_data[1:0];
          end
        end
        default: begin
          if (mbc1) begin
            banks.rom_mode = !a.write_data[0];
            if (banks.rom_mode) banks.ram_bank = 2'd0;
          end
        end
      endcase
    end else if (!a.is_write && a.bus_address[15:14] == 2'b01) begin
      r.region = cbc_pkg::REGION_ROM;
      r.mapped_address = {banks.rom_bank, a.bus_address[13:0]} & rom_mask;
    end else if (a.bus_address[15:13] == 3'b101) begin
      wrap = int'(banks.ram_bank) % cbc_pkg::RAM_BANKS;
      r.region = cbc_pkg::REGION_RAM;
      r.mapped_address = cbc_pkg::MAP_W'(int'(a.bus_address[12:0]) + wrap * 'h2000);
      r.ram_write_strobe = a.is_write && banks.ram_enable;
    end
    r.ram_is_enabled = banks.ram_enable;
    return r;
  endfunction

  // Offers one request after a random gap unless back_to_back, queues its expected result
  task automatic issue(input cbc_pkg::req_t a, input logic typed,
                       input cbc_pkg::rsp_t want);
    int            gap;
    cbc_pkg::rsp_t got;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.bus_address <= a.bus_address;
    req_ch.is_write    <= a.is_write;
    req_ch.write_data  <= a.write_data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = decode_access(a);
    decoded_q.push_back(typed ? want : got);
  endtask

  // Mapper change only with the pipe empty
  task automatic set_mapper(input logic [1:0] m);
    req_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mapper_sel = m;
  endtask

  plan_row_t plan [PLAN_LEN] = '{
    // after reset: no mapper, ROM bank 1, RAM off
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h4000, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_ROM, 21'h004000, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h7FFF, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_ROM, 21'h007FFF, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h0000, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_OTHER, 21'h0, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h0000, 1'b1, 8'h0A}, 1'b1,
      '{cbc_pkg::REGION_CTRL, 21'h0, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hBFFF, 1'b1, 8'hFF}, 1'b1,
      '{cbc_pkg::REGION_RAM, 21'h001FFF, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hFFFF, 1'b0, 8'hFF}, 1'b1,
      '{cbc_pkg::REGION_OTHER, 21'h00FFFF, 1'b0, 1'b0}},
    // unused mapper code acts as none
    '{1'b1, MAPPER_SPARE, '0, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h2000, 1'b1, 8'h05}, 1'b1,
      '{cbc_pkg::REGION_CTRL, 21'h002000, 1'b0, 1'b0}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h4000, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_ROM, 21'h004000, 1'b0, 1'b0}},
    // MBC1
    '{1'b1, cbc_pkg::MAPPER_MBC1, '0, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h1FFF, 1'b1, 8'hFA}, 1'b1,
      '{cbc_pkg::REGION_CTRL, 21'h001FFF, 1'b0, 1'b1}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hA000, 1'b1, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_RAM, 21'h0, 1'b1, 1'b1}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h2000, 1'b1, 8'h00}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h3FFF, 1'b1, 8'hFF}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h6000, 1'b1, 8'h00}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h4000, 1'b1, 8'hFF}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h7FFF, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_ROM, 21'h1FFFFF, 1'b0, 1'b1}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h7FFF, 1'b1, 8'h01}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h5FFF, 1'b1, 8'h03}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hBFFF, 1'b0, 8'h00}, 1'b1,
      '{cbc_pkg::REGION_RAM, 21'h007FFF, 1'b0, 1'b1}},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h0000, 1'b1, 8'hF0}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hA123, 1'b1, 8'h55}, 1'b0, '0},
    // MBC2: bit 8 blocks the RAM enable write, upper bank writes ignored
    '{1'b1, cbc_pkg::MAPPER_MBC2, '0, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h0100, 1'b1, 8'h0A}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h00FF, 1'b1, 8'h0A}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h2000, 1'b1, 8'hF0}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h4000, 1'b1, 8'h02}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h6000, 1'b1, 8'h00}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'h4000, 1'b0, 8'h00}, 1'b0, '0},
    '{1'b0, cbc_pkg::MAPPER_NONE, '{16'hC000, 1'b1, 8'h5A}, 1'b0, '0}
  };

  // Receiver: random stall per result, one long hold-off on request
  initial begin
    int            stall;
    cbc_pkg::rsp_t want;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, 19);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (decoded_q.size() == 0) begin
        $display("%0t: result with none outstanding, got region %0d address %h",
                 $time, rsp_ch.region, rsp_ch.mapped_address);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (rsp_ch.region !== want.region) begin
          $display("%0t: region expected %0d got %0d", $time, want.region, rsp_ch.region);
          errors++;
        end
        if (rsp_ch.mapped_address !== want.mapped_address) begin
          $display("%0t: mapped_address expected %h got %h", $time,
                   want.mapped_address, rsp_ch.mapped_address);
          errors++;
        end
        if (rsp_ch.ram_write_strobe !== want.ram_write_strobe) begin
          $display("%0t: ram_write_strobe expected %0b got %0b", $time,
                   want.ram_write_strobe, rsp_ch.ram_write_strobe);
          errors++;
        end
        if (rsp_ch.ram_is_enabled !== want.ram_is_enabled) begin
          $display("%0t: ram_is_enabled expected %0b got %0b", $time,
                   want.ram_is_enabled, rsp_ch.ram_is_enabled);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]    phase_mapper [7];
    cbc_pkg::req_t a;
    int            pick;
    phase_mapper = '{cbc_pkg::MAPPER_MBC1, cbc_pkg::MAPPER_MBC1, cbc_pkg::MAPPER_MBC2,
                     cbc_pkg::MAPPER_NONE, cbc_pkg::MAPPER_MBC2, MAPPER_SPARE,
                     cbc_pkg::MAPPER_MBC1};
    req_ch.valid       <= 1'b0;
    req_ch.bus_address <= '0;
    req_ch.is_write    <= 1'b0;
    req_ch.write_data  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= cbc_pkg::MAPPER_NONE;
    mapper_sel = cbc_pkg::MAPPER_NONE;
    banks = '{rom_bank: 7'd1, ram_bank: 2'd0, ram_enable: 1'b0, rom_mode: 1'b0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_mapper(plan[i].mapper);
      else issue(plan[i].acc, plan[i].typed, plan[i].want);
    end

    foreach (phase_mapper[p]) begin
      set_mapper(phase_mapper[p]);
      // second phase: no idling at all, and the receiver holds off for a
      // long stretch so the pipe fills and req stalls
      back_to_back = (p == 1);
      if (p == 1) hold_len = HOLD_CYCLES;
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        a.write_data = 8'($urandom);
        if (pick < 28) begin
          // control write into one of the four windows
          a.bus_address = {1'b0, 2'($urandom_range(0, 3)), 13'($urandom)};
          a.is_write = 1'b1;
          if (a.bus_address[14:13] == cbc_pkg::CW_RAM_EN) begin
            case ($urandom_range(0, 2))
              0: a.write_data[3:0] = cbc_pkg::RAM_EN_KEY;
              1: a.write_data[3:0] = cbc_pkg::RAM_DIS_KEY;
              default: ;
            endcase
          end
        end else if (pick < 52) begin
          a.bus_address = {2'b01, 14'($urandom)};
          a.is_write = 1'b0;
        end else if (pick < 77) begin
          a.bus_address = {3'b101, 13'($urandom)};
          a.is_write = 1'($urandom);
        end else if (pick < 85) begin
          a.bus_address = {2'b00, 14'($urandom)};
          a.is_write = 1'b0;
        end else begin
          a.bus_address = 16'($urandom);
          a.is_write = 1'($urandom);
        end
        issue(a, 1'b0, '0);
      end
      back_to_back = 1'b0;
    end

    req_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
